@@ rtl/dh_chain_forward_kinematics_top_macros.svh @@
// assertion macros for the kinematics block
`ifndef DH_CHAIN_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define DH_CHAIN_FORWARD_KINEMATICS_TOP_MACROS_SVH
// implication checked on every clock, reset masked
`define DHFK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define DHFK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/dhfk_pkg.sv @@
// shared types, constants and cordic table for the kinematics block
`timescale 1ns / 1ps
package dhfk_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_RUN = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int STG_W = $clog2(CORDIC_RUN + 1);
    localparam logic signed [19:0] FLANGE_RESET = 20'sd7012;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [27:0] PI_Q24 = 28'sd52707179;
    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic signed [19:0] link_length;
        logic signed [17:0] link_twist;
        logic signed [19:0] link_offset;
        logic signed [17:0] joint_angle;
        logic               last_joint;
    } joint_t;

    function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
        logic signed [27:0] r;
        begin
            case (i)
                5'd0: r = 28'sd13176795;
                5'd1: r = 28'sd7778716;
                5'd2: r = 28'sd4110060;
                5'd3: r = 28'sd2086331;
                5'd4: r = 28'sd1047214;
                5'd5: r = 28'sd524117;
                5'd6: r = 28'sd262123;
                5'd7: r = 28'sd131069;
                default: r = 28'sd65536 >>> (i - 5'd8);
            endcase
            return r;
        end
    endfunction

    // round to nearest, ties away from zero, by 16 bits
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            if (v >= 0)
                r = (v + 64'sd32768) >>> 16;
            else
                r = -((-v + 64'sd32768) >>> 16);
            return r;
        end
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                 input logic signed [63:0] hi);
        logic signed [63:0] r;
        begin
            if (v > hi)
                r = hi;
            else if (v < -hi - 64'sd1)
                r = -hi - 64'sd1;
            else
                r = v;
            return r;
        end
    endfunction
endpackage

@@ rtl/dh_chain_forward_kinematics_top.sv @@
// top level of the serial-arm forward kinematics block
// joint words are processed one at a time, each by the iterative cordic and then
// by the pose product on a single multiply-accumulate; the result word of a last
// joint is held while the output stalls
// a two-entry queue buffers joint words during the computation
// reset clears pose to identity and flange offset to 7012
`timescale 1ns / 1ps
module dh_chain_forward_kinematics_top
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [19:0] link_length,
    input  logic signed [17:0] link_twist,
    input  logic signed [19:0] link_offset,
    input  logic signed [17:0] joint_angle,
    input  logic               last_joint,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] pos_x,
    output logic signed [19:0] pos_y,
    output logic signed [19:0] pos_z,
    input  logic               cfg_we,
    input  logic signed [19:0] cfg_wdata
);
    joint_t             in_word, q_word;
    logic               q_valid, q_pop;
    logic signed [19:0] flange_reg;

    assign in_word = '{link_length, link_twist, link_offset, joint_angle, last_joint};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flange_reg <= FLANGE_RESET;
        else if (cfg_we)
            flange_reg <= cfg_wdata;
    end

    dhfk_front u_front (.clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .in_word(in_word), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word));

    dhfk_back u_back (.clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_word(q_word), .flange(flange_reg), .valid(out_valid), .stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z));
endmodule

@@ rtl/dhfk_front.sv @@
// input stage: accepts joint words into a short queue
`timescale 1ns / 1ps
module dhfk_front
    import dhfk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid,
    output logic   stall,
    input  joint_t in_word,
    output logic   q_valid,
    input  logic   q_pop,
    output joint_t q_word
);
    joint_t     mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign stall = (cnt_reg == 2'(QDEPTH));
    assign push = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_word;
    end
endmodule

@@ rtl/dhfk_cordic.sv @@
// iterative cordic, one stage per cycle, sine and cosine of one angle
`timescale 1ns / 1ps
module dhfk_cordic
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [17:0] angle,
    output logic               done,
    output logic signed [17:0] cos_out,
    output logic signed [17:0] sin_out
);
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [27:0] z_reg, z_next, z0;
    logic               flip_reg, flip_next, busy_reg, busy_next;
    logic [STG_W-1:0]   i_reg, i_next;
    logic signed [33:0] dx, dy;
    logic signed [63:0] xr, yr;

    always_comb
    begin
        z0 = 28'(angle) <<< 9;
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        i_next = i_reg;
        if (start)
        begin
            x_next = CORDIC_START;
            y_next = '0;
            flip_next = 1'b0;
            z_next = z0;
            if (z0 > HALF_PI_Q24)
            begin
                z_next = z0 - PI_Q24;
                flip_next = 1'b1;
            end
            else if (z0 < -HALF_PI_Q24)
            begin
                z_next = z0 + PI_Q24;
                flip_next = 1'b1;
            end
            i_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_q24(5'(i_reg));
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_q24(5'(i_reg));
            end
            i_next = i_reg + 1'b1;
            if (i_reg == STG_W'(CORDIC_RUN - 1))
                busy_next = 1'b0;
        end
    end

    assign done = busy_reg && (i_reg == STG_W'(CORDIC_RUN - 1));

    // rounding on the final stage result
    always_comb
    begin
        xr = 64'(x_next);
        yr = 64'(y_next);
        xr = (xr >= 0) ? ((xr + 64'sd8192) >>> 14) : -((-xr + 64'sd8192) >>> 14);
        yr = (yr >= 0) ? ((yr + 64'sd8192) >>> 14) : -((-yr + 64'sd8192) >>> 14);
        xr = sat64(xr, 64'sd65536);
        yr = sat64(yr, 64'sd65536);
        if (xr < -64'sd65536) xr = -64'sd65536;
        if (yr < -64'sd65536) yr = -64'sd65536;
        cos_out = flip_reg ? -18'(xr) : 18'(xr);
        sin_out = flip_reg ? -18'(yr) : 18'(yr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
    end
endmodule

@@ rtl/dhfk_back.sv @@
// execution stage: cordic, sequenced pose product on one multiplier, output
`timescale 1ns / 1ps
module dhfk_back
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  joint_t             q_word,
    input  logic signed [19:0] flange,
    output logic               valid,
    input  logic               stall,
    output logic signed [19:0] pos_x,
    output logic signed [19:0] pos_y,
    output logic signed [19:0] pos_z
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORD = 3'd1;
    localparam logic [2:0] S_JNT = 3'd2;
    localparam logic [2:0] S_MAC = 3'd3;
    localparam logic [2:0] S_WB = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]         st_reg, st_next;
    joint_t             w_reg;
    logic signed [17:0] rot_reg [9];
    logic signed [23:0] tr_reg [3];
    logic signed [17:0] nr_reg [9];
    logic signed [17:0] jr_reg [9];
    logic signed [20:0] jp_reg [3];
    logic signed [17:0] ct_reg, st_reg2, ca_reg, sa_reg;
    logic [1:0]         jstep_reg;
    logic [1:0]         r_reg, k_reg, m_reg;
    logic signed [63:0] acc_reg, acct_reg;
    logic               ovalid_reg;
    logic signed [19:0] ox_reg, oy_reg, oz_reg;
    logic               c_done_t, c_done_a;
    logic signed [17:0] c_ct, c_st, c_ca, c_sa;
    logic               cstart;
    logic               out_free;
    logic signed [37:0] jprod;
    logic signed [19:0] ja, jb;
    logic signed [63:0] mprod;
    logic signed [23:0] ma, mb;
    logic signed [63:0] prod_ext;
    logic [3:0]         ri, ji;

    assign cstart = (st_reg == S_IDLE) && q_valid;
    assign q_pop = cstart;
    assign valid = ovalid_reg;
    assign out_free = !ovalid_reg || !stall;
    assign pos_x = ox_reg;
    assign pos_y = oy_reg;
    assign pos_z = oz_reg;

    dhfk_cordic u_ct (.clk(clk), .rst_n(rst_n), .start(cstart),
        .angle(q_word.joint_angle), .done(c_done_t), .cos_out(c_ct), .sin_out(c_st));
    dhfk_cordic u_ca (.clk(clk), .rst_n(rst_n), .start(cstart),
        .angle(q_word.link_twist), .done(c_done_a), .cos_out(c_ca), .sin_out(c_sa));

    // joint-transform product operands, one per cycle
    always_comb
    begin
        case (jstep_reg)
            2'd0: begin ja = 20'(st_reg2); jb = 20'(ca_reg); end
            2'd1: begin ja = 20'(ct_reg); jb = 20'(ca_reg); end
            2'd2: begin ja = 20'(st_reg2); jb = 20'(sa_reg); end
            default: begin ja = 20'(ct_reg); jb = 20'(sa_reg); end
        endcase
        jprod = 38'(ja) * 38'(jb);
    end

    // pose product operands
    always_comb
    begin
        ri = 4'(r_reg) * 4'd3;
        ji = 4'(m_reg) * 4'd3 + 4'(k_reg);
        if (st_reg == S_OUT)
        begin
            ma = 24'(rot_reg[ri + 4'd2]);
            mb = 24'(flange);
        end
        else if (k_reg == 2'd3)
        begin
            ma = 24'(rot_reg[ri + 4'(m_reg)]);
            mb = 24'(jp_reg[m_reg]);
        end
        else
        begin
            ma = 24'(rot_reg[ri + 4'(m_reg)]);
            mb = 24'(jr_reg[ji]);
        end
        mprod = 64'(ma) * 64'(mb);
        prod_ext = 64'(tr_reg[r_reg]) <<< 16;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (q_valid) st_next = S_CORD;
            S_CORD: if (c_done_t && c_done_a) st_next = S_JNT;
            S_JNT: if (jstep_reg == 2'd3) st_next = S_MAC;
            S_MAC: if (m_reg == 2'd2 && k_reg == 2'd3 && r_reg == 2'd2) st_next = S_WB;
            S_WB: st_next = w_reg.last_joint ? S_OUT : S_IDLE;
            S_OUT: if (r_reg == 2'd2 && out_free) st_next = S_EMIT;
            S_EMIT: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            jstep_reg <= '0;
            r_reg <= '0;
            k_reg <= '0;
            m_reg <= '0;
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= (i % 4 == 0) ? ONE_Q16 : 18'sd0;
            for (int i = 0; i < 3; i++)
                tr_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (ovalid_reg && !stall)
                ovalid_reg <= 1'b0;
            case (st_reg)
                S_CORD:
                begin
                    jstep_reg <= '0;
                end
                S_JNT:
                begin
                    jstep_reg <= jstep_reg + 2'd1;
                    r_reg <= '0;
                    k_reg <= '0;
                    m_reg <= '0;
                end
                S_MAC:
                begin
                    if (m_reg == 2'd2)
                    begin
                        m_reg <= '0;
                        if (k_reg == 2'd3)
                        begin
                            k_reg <= '0;
                            r_reg <= r_reg + 2'd1;
                        end
                        else
                            k_reg <= k_reg + 2'd1;
                    end
                    else
                        m_reg <= m_reg + 2'd1;
                end
                S_WB:
                begin
                    for (int i = 0; i < 9; i++)
                        rot_reg[i] <= nr_reg[i];
                    r_reg <= '0;
                end
                S_OUT:
                begin
                    if (out_free)
                        r_reg <= r_reg + 2'd1;
                end
                S_EMIT:
                begin
                    ovalid_reg <= 1'b1;
                    for (int i = 0; i < 9; i++)
                        rot_reg[i] <= (i % 4 == 0) ? ONE_Q16 : 18'sd0;
                    for (int i = 0; i < 3; i++)
                        tr_reg[i] <= '0;
                end
                default: ;
            endcase
            // translation written as each row closes
            if (st_reg == S_MAC && m_reg == 2'd2 && k_reg == 2'd3)
                tr_reg[r_reg] <= 24'(sat64(rnd16(acct_reg + mprod), 64'sd8388607));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cstart)
            w_reg <= q_word;
        if (st_reg == S_CORD && c_done_t && c_done_a)
        begin
            ct_reg <= c_ct;
            st_reg2 <= c_st;
            ca_reg <= c_ca;
            sa_reg <= c_sa;
        end
        if (st_reg == S_JNT)
        begin
            case (jstep_reg)
                2'd0:
                begin
                    jr_reg[3] <= 18'(rnd16(64'(jprod)));
                    jr_reg[0] <= ct_reg;
                    jr_reg[1] <= -st_reg2;
                    jr_reg[2] <= '0;
                    jr_reg[5] <= -sa_reg;
                    jr_reg[8] <= ca_reg;
                    jp_reg[0] <= 21'(w_reg.link_length);
                    jp_reg[1] <= 21'(-rnd16(64'(w_reg.link_offset) * 64'(sa_reg)));
                    jp_reg[2] <= 21'(rnd16(64'(w_reg.link_offset) * 64'(ca_reg)));
                end
                2'd1: jr_reg[4] <= 18'(rnd16(64'(jprod)));
                2'd2: jr_reg[6] <= 18'(rnd16(64'(jprod)));
                default: jr_reg[7] <= 18'(rnd16(64'(jprod)));
            endcase
        end
        if (st_reg == S_MAC)
        begin
            if (k_reg == 2'd3)
            begin
                if (m_reg == 2'd0)
                    acct_reg <= prod_ext + mprod;
                else
                    acct_reg <= acct_reg + mprod;
            end
            else
            begin
                if (m_reg == 2'd0)
                    acc_reg <= mprod;
                else
                    acc_reg <= acc_reg + mprod;
                if (m_reg == 2'd2)
                    nr_reg[ri + 4'(k_reg)] <=
                        18'(sat64(rnd16(acc_reg + mprod), 64'sd131071));
            end
        end
        if (st_reg == S_OUT && out_free)
        begin
            case (r_reg)
                2'd0: ox_reg <= 20'(sat64(rnd16(prod_ext + mprod), 64'sd524287));
                2'd1: oy_reg <= 20'(sat64(rnd16(prod_ext + mprod), 64'sd524287));
                default: oz_reg <= 20'(sat64(rnd16(prod_ext + mprod), 64'sd524287));
            endcase
        end
    end
endmodule

@@ rtl/dhfk_checker.sv @@
// port-level checker for the kinematics block, bound to the top level
`timescale 1ns / 1ps
`include "dh_chain_forward_kinematics_top_macros.svh"
module dhfk_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [19:0] pos_x,
    input logic signed [19:0] pos_y,
    input logic signed [19:0] pos_z
);
    `DHFK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `DHFK_ASSERT_NEXT(a_pos_hold, clk, rst_n, out_valid && out_stall, $stable({pos_x, pos_y, pos_z}))
    `DHFK_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, out_valid && !out_stall, !out_valid)
    `DHFK_ASSERT_IMP(a_in_known, clk, rst_n, 1'b1, !$isunknown({in_valid, in_stall}))
endmodule

bind dh_chain_forward_kinematics_top dhfk_checker u_checker (.clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z));

@@ test/dh_chain_forward_kinematics_top_tb.sv @@
// self-checking testbench for the dh chain forward kinematics block
`timescale 1ns / 1ps
module dh_chain_forward_kinematics_top_tb;
    import dhfk_pkg::*;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } flange_pos_t;

    typedef struct {
        joint_t      word;
        logic        known;
        flange_pos_t pos;
    } dir_row_t;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = CORDIC_STAGES + 60;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [19:0] link_length;
    logic signed [17:0] link_twist;
    logic signed [19:0] link_offset;
    logic signed [17:0] joint_angle;
    logic               last_joint;
    logic               out_valid;
    logic               out_stall;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic               cfg_we;
    logic signed [19:0] cfg_wdata;

    dh_chain_forward_kinematics_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .link_length(link_length), .link_twist(link_twist),
        .link_offset(link_offset), .joint_angle(joint_angle),
        .last_joint(last_joint),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    longint      arm_rot[9];
    longint      arm_trans[3];
    longint      flange_q16;
    flange_pos_t pos_queue[$];
    int          fail_count;
    int          idle_cycles;
    logic        calm_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint round_q16(longint v, int s = 16);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint floor_sh(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint t[8];
        t = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
        if (i < 8)
            return t[i];
        return longint'(65536) >>> (i - 8);
    endfunction

    task automatic rotate_angle(input longint ang, output longint c, output longint s);
        longint zz;
        longint xx;
        longint yy;
        longint dx;
        longint dy;
        logic   flip;
        zz = ang * 512;
        xx = 652032874;
        yy = 0;
        flip = 1'b0;
        if (zz > 26353589)
        begin
            zz -= 52707179;
            flip = 1'b1;
        end
        else if (zz < -26353589)
        begin
            zz += 52707179;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = floor_sh(yy, i);
            dy = floor_sh(xx, i);
            if (zz >= 0)
            begin
                xx -= dx; yy += dy; zz -= atan_step(i);
            end
            else
            begin
                xx += dx; yy -= dy; zz += atan_step(i);
            end
        end
        xx = round_q16(xx, 14);
        yy = round_q16(yy, 14);
        xx = xx > 65536 ? 65536 : (xx < -65536 ? -65536 : xx);
        yy = yy > 65536 ? 65536 : (yy < -65536 ? -65536 : yy);
        c = flip ? -xx : xx;
        s = flip ? -yy : yy;
    endtask

    task automatic pose_identity();
        for (int i = 0; i < 9; i++)
            arm_rot[i] = (i % 4 == 0) ? 65536 : 0;
        for (int i = 0; i < 3; i++)
            arm_trans[i] = 0;
    endtask

    task automatic chain_joint(input joint_t w, output logic emits, output flange_pos_t p);
        longint ct, st, ca, sa, acc, acc_t, dl;
        longint jr[9];
        longint jp[3];
        longint nr[9];
        longint np[3];
        longint v[3];
        rotate_angle(longint'(w.joint_angle), ct, st);
        rotate_angle(longint'(w.link_twist), ca, sa);
        dl = longint'(w.link_offset);
        jr[0] = ct; jr[1] = -st; jr[2] = 0;
        jr[3] = round_q16(st * ca); jr[4] = round_q16(ct * ca); jr[5] = -sa;
        jr[6] = round_q16(st * sa); jr[7] = round_q16(ct * sa); jr[8] = ca;
        jp[0] = longint'(w.link_length);
        jp[1] = -round_q16(dl * sa);
        jp[2] = round_q16(dl * ca);
        for (int r = 0; r < 3; r++)
        begin
            acc_t = arm_trans[r] * 65536;
            for (int k = 0; k < 3; k++)
            begin
                acc = 0;
                for (int m = 0; m < 3; m++)
                    acc += arm_rot[r * 3 + m] * jr[m * 3 + k];
                nr[r * 3 + k] = clip(round_q16(acc), 18);
                acc_t += arm_rot[r * 3 + k] * jp[k];
            end
            np[r] = clip(round_q16(acc_t), 24);
        end
        arm_rot = nr;
        arm_trans = np;
        emits = w.last_joint;
        p = '0;
        if (w.last_joint)
        begin
            for (int r = 0; r < 3; r++)
                v[r] = clip(round_q16(arm_trans[r] * 65536
                                     + arm_rot[r * 3 + 2] * flange_q16), 20);
            p.x = v[0][19:0];
            p.y = v[1][19:0];
            p.z = v[2][19:0];
            pose_identity();
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // result side: stall at random unless calm_out is set, check each accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pos_queue.size() == 0)
                    report_mismatch("unexpected word", pos_x, 0);
                else
                begin
                    flange_pos_t e;
                    e = pos_queue.pop_front();
                    if (pos_x !== e.x) report_mismatch("pos_x", pos_x, e.x);
                    if (pos_y !== e.y) report_mismatch("pos_y", pos_y, e.y);
                    if (pos_z !== e.z) report_mismatch("pos_z", pos_z, e.z);
                end
            end
            out_stall <= calm_out ? 1'b0 : ($urandom_range(99) < 32);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_joint(input joint_t w, input logic calm);
        logic        emits;
        flange_pos_t p;
        while (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        link_length <= w.link_length;
        link_twist  <= w.link_twist;
        link_offset <= w.link_offset;
        joint_angle <= w.joint_angle;
        last_joint  <= w.last_joint;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chain_joint(w, emits, p);
        if (emits)
            pos_queue.push_back(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pos_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_flange(input logic signed [19:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        flange_q16 = longint'(v);
    endtask

    function automatic joint_t random_joint(input logic fin);
        joint_t w;
        w.link_length = $urandom_range(3) == 0 ? 20'($urandom)
                      : 20'($signed($urandom_range(65536)) - 32768);
        w.link_twist  = 18'($urandom);
        w.link_offset = $urandom_range(3) == 0 ? 20'($urandom)
                      : 20'($signed($urandom_range(65536)) - 32768);
        w.joint_angle = 18'($urandom);
        w.last_joint  = fin;
        return w;
    endfunction

    dir_row_t dir_rows[$];
    joint_t   jw;
    int       sent;
    int       chain_len;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        link_length = '0;
        link_twist = '0;
        link_offset = '0;
        joint_angle = '0;
        last_joint = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        idle_cycles = 0;
        calm_out = 1'b0;
        flange_q16 = 7012;
        pose_identity();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; zero joint gives flange offset straight up z
        dir_rows.push_back('{'{20'sd0, 18'sd0, 20'sd0, 18'sd0, 1'b1}, 1'b1,
                             '{20'sd0, 20'sd0, 20'sd7012}});
        dir_rows.push_back('{'{20'sd65536, 18'sd0, 20'sd0, 18'sd0, 1'b1}, 1'b1,
                             '{20'sd65536, 20'sd0, 20'sd7012}});
        dir_rows.push_back('{'{20'sd0, 18'sd0, 20'sd65536, 18'sd0, 1'b1}, 1'b0, '0});
        dir_rows.push_back('{'{20'sd524287, 18'sd0, 20'sd524287, 18'sd0, 1'b0}, 1'b0, '0});
        dir_rows.push_back('{'{20'sd524287, 18'sd0, 20'sd524287, 18'sd0, 1'b1}, 1'b0, '0});
        dir_rows.push_back('{'{-20'sd524288, 18'sd0, -20'sd524288, 18'sd0, 1'b0}, 1'b0, '0});
        dir_rows.push_back('{'{-20'sd524288, 18'sd0, -20'sd524288, 18'sd0, 1'b1}, 1'b0, '0});
        dir_rows.push_back('{'{20'sd0, 18'sd131071, 20'sd0, -18'sd131072, 1'b0}, 1'b0, '0});
        dir_rows.push_back('{'{20'sd0, -18'sd131072, 20'sd0, 18'sd131071, 1'b1}, 1'b0, '0});
        dir_rows.push_back('{'{20'sd32768, 18'sd51472, 20'sd1000, 18'sd51472, 1'b0},
                             1'b0, '0});
        dir_rows.push_back('{'{20'sd32768, -18'sd51472, 20'sd2000, -18'sd51472, 1'b0},
                             1'b0, '0});
        dir_rows.push_back('{'{20'sd40000, 18'sd102944, 20'sd3000, 18'sd25736, 1'b1},
                             1'b0, '0});
        dir_rows.push_back('{'{20'sd12345, 18'sd51471, 20'sd54321, 18'sd51473, 1'b1},
                             1'b0, '0});
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].known)
                drain();
            send_joint(dir_rows[i].word, 1'b1);
            if (dir_rows[i].known)
            begin
                void'(pos_queue.pop_back());
                pos_queue.push_back(dir_rows[i].pos);
            end
        end

        // register extremes and mid values, with random chains in between
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_flange(20'sd524287);
                1: write_flange(-20'sd524288);
                2: write_flange(20'($urandom));
                3: write_flange(20'sd0);
                default: write_flange(20'sd7012);
            endcase
            calm_out = (phase == 2);
            for (int n = 0; n < 160; n += chain_len)
            begin
                chain_len = $urandom_range(7, 1);
                for (int j = 0; j < chain_len; j++)
                begin
                    jw = random_joint(j == chain_len - 1);
                    send_joint(jw, phase == 2);
                    sent++;
                end
                if (sent % 97 < 7)
                    drain();
            end
        end
        calm_out = 1'b0;

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
